// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset only.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset only.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/mede_pkg.sv -----
package mede_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int KROWS      = 3;
  localparam int MEM_DEPTH  = KROWS * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int NUM_SLOTS  = 12;
  localparam int SLOT_W     = 4;
  localparam int ERR_W      = 17;
  localparam int MAG_W      = 16;
  localparam int PROD_W     = 24;
  localparam int DIVR_W     = 10;
  localparam int CNT_W      = 5;

  localparam logic [7:0] OUT_WHITE       = 8'd255;
  localparam logic [7:0] OUT_BLACK       = 8'd0;
  localparam logic [7:0] OUT_TRANSPARENT = 8'd128;

  typedef enum logic [2:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_SERP,
    CFG_WROW0,
    CFG_WROW1,
    CFG_WROW2,
    CFG_DIVISOR
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ERR,
    ST_SLOT,
    ST_DSTART,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load_pix;
    logic rd_cur;
    logic calc_err;
    logic nb_issue;
    logic div_start;
    logic wb;
    logic slot_next;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic opaque;
    logic slot_ok;
    logic slot_last;
    logic div_done;
    logic div_busy;
    logic out_free;
    logic row_end;
  } dp_sts_t;

endpackage

// ----- design/mono_error_diffusion_dither.sv -----
// Channel   Direction  Payload
// in_       input      tdata: pixel_value[12:0]; tuser: opaque
// out_      output     tdata: out_value[7:0]; tlast: frame_end
// cfg_      input      register index, write data, write enable
//
// A transparent pixel is read, quantized and finished without the kernel
// walk; an opaque one also walks every kernel slot and runs the serial
// 24-step divider for every tap that lands in the image with a nonzero weight.
// After reset, and at each frame end, a clearing pass sweeps all 3072 words
// of the error lines; any other row end sweeps the finished line's 1024 words.
// A result waits in the output register while the next pixel is taken in;
// a pixel finishes only once that register is free.
`include "assert_macros.svh"

module mono_error_diffusion_dither (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [12:0] pixel_value, [15:13] zero
  input  logic        in_tuser,   // [0] opaque
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_value
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [39:0] cfg_wdata
);
  import mede_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mede_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mede_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  `ASSERT_IMPLY(a_idle_div_quiet, clk, rst_n, in_tready, !sts.div_busy)
  `ASSERT_NEXT(a_one_pixel, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMPLY(a_finish_free, clk, rst_n, cmd.finish, sts.out_free)

endmodule

// ----- design/mede_div.sv -----
module mede_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mede_pkg::PROD_W-1:0]  dividend,
  input  logic [mede_pkg::DIVR_W-1:0]  divisor,
  output logic [mede_pkg::PROD_W-1:0]  quotient,
  output logic                         busy,
  output logic                         done
);
  import mede_pkg::*;

  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [DIVR_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DIVR_W:0]   trial;
  logic              ge;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial   = {rem_r, quo_r[PROD_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? DIVR_W'(trial - {1'b0, dvs_r}) : trial[DIVR_W-1:0];
    quo_nxt = {quo_r[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PROD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;
  assign done     = done_r;

endmodule

// ----- design/mede_ctrl.sv -----
module mede_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mede_pkg::dp_sts_t sts,
  output mede_pkg::dp_cmd_t cmd
);
  import mede_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_ERR;
      ST_ERR:    state_nxt = sts.opaque ? ST_SLOT : ST_DONE;
      ST_SLOT: begin
        if (sts.slot_ok) begin
          state_nxt = ST_DSTART;
        end else if (sts.slot_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (sts.div_done) state_nxt = ST_WB;
      ST_WB:     state_nxt = sts.slot_last ? ST_DONE : ST_SLOT;
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = sts.row_end ? ST_CLEAR : ST_IDLE;
        end
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_pix = in_tvalid;
      end
      ST_READ:   cmd.rd_cur = 1'b1;
      ST_ERR:    cmd.calc_err = 1'b1;
      ST_SLOT: begin
        cmd.nb_issue  = sts.slot_ok;
        cmd.slot_next = !sts.slot_ok;
      end
      ST_DSTART: cmd.div_start = 1'b1;
      ST_DIV:    cmd = '0;
      ST_WB: begin
        cmd.wb        = 1'b1;
        cmd.slot_next = 1'b1;
      end
      ST_DONE:   cmd.finish = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- design/mede_dp.sv -----
module mede_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [39:0]       cfg_wdata,
  input  logic [15:0]       in_tdata,
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  input  mede_pkg::dp_cmd_t cmd,
  output mede_pkg::dp_sts_t sts
);
  import mede_pkg::*;

  // Configuration registers.
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic        serp_r;
  logic [15:0] wrow0_r;
  logic [39:0] wrow1_r, wrow2_r;
  logic [9:0]  divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 11'd640;
      height_r  <= 16'd480;
      serp_r    <= 1'b0;
      wrow0_r   <= 16'd7;
      wrow1_r   <= 40'd17105664;
      wrow2_r   <= 40'd0;
      divisor_r <= 10'd16;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_WIDTH:   width_r   <= cfg_wdata[10:0];
        CFG_HEIGHT:  height_r  <= cfg_wdata[15:0];
        CFG_SERP:    serp_r    <= cfg_wdata[0];
        CFG_WROW0:   wrow0_r   <= cfg_wdata[15:0];
        CFG_WROW1:   wrow1_r   <= cfg_wdata;
        CFG_WROW2:   wrow2_r   <= cfg_wdata;
        CFG_DIVISOR: divisor_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  logic [10:0] w_eff;
  logic [15:0] h_eff;
  logic [9:0]  div_eff;

  always_comb begin
    if (width_r == 11'd0) begin
      w_eff = 11'd1;
    end else if (width_r > 11'(MAX_WIDTH)) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff   = (height_r == 16'd0) ? 16'd1 : height_r;
    div_eff = (divisor_r == 10'd0) ? 10'd1 : divisor_r;
  end

  // Scan position.
  logic [COL_W-1:0] col_r, cur_col_r, x_r;
  logic [15:0]      row_r, cur_row_r;
  logic             rev_r;
  logic [1:0]       rot_r;
  logic             last_col_r, last_row_r;
  logic [12:0]      pix_r;
  logic             opq_r;

  logic [10:0] ccol;
  logic [15:0] crow;

  always_comb begin
    ccol = ({1'b0, col_r} >= w_eff) ? 11'(w_eff - 11'd1) : {1'b0, col_r};
    crow = (row_r >= h_eff) ? 16'(h_eff - 16'd1) : row_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      pix_r      <= in_tdata[12:0];
      opq_r      <= in_tuser;
      cur_col_r  <= ccol[COL_W-1:0];
      cur_row_r  <= crow;
      x_r        <= rev_r ? COL_W'(w_eff - 11'd1 - ccol) : ccol[COL_W-1:0];
      last_col_r <= (ccol + 11'd1) >= w_eff;
      last_row_r <= ({1'b0, crow} + 17'd1) >= {1'b0, h_eff};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rev_r <= 1'b0;
      rot_r <= '0;
    end else if (cmd.finish) begin
      if (!last_col_r) begin
        col_r <= cur_col_r + 1'b1;
      end else begin
        col_r <= '0;
        if (last_row_r) begin
          row_r <= '0;
          rot_r <= '0;
          rev_r <= 1'b0;
        end else begin
          row_r <= cur_row_r + 16'd1;
          rot_r <= (rot_r == 2'd2) ? 2'd0 : rot_r + 2'd1;
          // The next row is odd exactly when this one is even.
          rev_r <= serp_r && !cur_row_r[0];
        end
      end
    end
  end

  // Error lines and the clearing sweep.
  logic [15:0]       mem [MEM_DEPTH];
  logic [15:0]       rdata_r;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_ra, mem_wa, tgt_addr_r, cur_addr, clr_addr_r, clr_end_r;
  logic [15:0]       mem_wd, sat_sum;

  assign cur_addr = {rot_r, x_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_end_r  <= ADDR_W'(MEM_DEPTH - 1);
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end else if (cmd.finish && last_col_r) begin
      if (last_row_r) begin
        clr_addr_r <= '0;
        clr_end_r  <= ADDR_W'(MEM_DEPTH - 1);
      end else begin
        clr_addr_r <= {rot_r, {COL_W{1'b0}}};
        clr_end_r  <= {rot_r, {COL_W{1'b1}}};
      end
    end
  end

  always_comb begin
    mem_re = cmd.rd_cur || cmd.nb_issue;
    mem_we = cmd.clr_step || cmd.rd_cur || cmd.wb;
    mem_wa = cmd.clr_step ? clr_addr_r : (cmd.rd_cur ? cur_addr : tgt_addr_r);
    mem_wd = cmd.wb ? sat_sum : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Quantize.
  logic [ERR_W-1:0] err_r, vsum;
  logic [7:0]       ov_r;
  logic             white;

  always_comb begin
    vsum  = {4'b0, pix_r} + {rdata_r[15], rdata_r};
    white = $signed(vsum) > $signed(ERR_W'(2048));
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      err_r <= white ? ERR_W'(vsum - ERR_W'(4096)) : vsum;
      if (!opq_r) begin
        ov_r <= OUT_TRANSPARENT;
      end else begin
        ov_r <= white ? OUT_WHITE : OUT_BLACK;
      end
    end
  end

  // Kernel slot walk: two forward taps on this row, five on each row below.
  logic [SLOT_W-1:0] slot_r;
  logic [1:0]        dy;
  logic [2:0]        kk, k_eff;
  logic [7:0]        wt;
  logic [11:0]       tx;
  logic [2:0]        line_sum;
  logic [1:0]        line;
  logic              tx_ok, row_ok;

  always_comb begin
    unique case (slot_r)
      4'd0:  begin dy = 2'd0; kk = 3'd1;    wt = wrow0_r[7:0];   end
      4'd1:  begin dy = 2'd0; kk = 3'd2;    wt = wrow0_r[15:8];  end
      4'd2:  begin dy = 2'd1; kk = -3'sd2;  wt = wrow1_r[7:0];   end
      4'd3:  begin dy = 2'd1; kk = -3'sd1;  wt = wrow1_r[15:8];  end
      4'd4:  begin dy = 2'd1; kk = 3'd0;    wt = wrow1_r[23:16]; end
      4'd5:  begin dy = 2'd1; kk = 3'd1;    wt = wrow1_r[31:24]; end
      4'd6:  begin dy = 2'd1; kk = 3'd2;    wt = wrow1_r[39:32]; end
      4'd7:  begin dy = 2'd2; kk = -3'sd2;  wt = wrow2_r[7:0];   end
      4'd8:  begin dy = 2'd2; kk = -3'sd1;  wt = wrow2_r[15:8];  end
      4'd9:  begin dy = 2'd2; kk = 3'd0;    wt = wrow2_r[23:16]; end
      4'd10: begin dy = 2'd2; kk = 3'd1;    wt = wrow2_r[31:24]; end
      4'd11: begin dy = 2'd2; kk = 3'd2;    wt = wrow2_r[39:32]; end
      default: begin dy = 2'd0; kk = 3'd0;  wt = 8'd0;           end
    endcase
    k_eff    = rev_r ? 3'(-kk) : kk;
    tx       = {2'b00, x_r} + {{9{k_eff[2]}}, k_eff};
    tx_ok    = !tx[11] && (tx[10:0] < w_eff);
    row_ok   = ({1'b0, cur_row_r} + {15'd0, dy}) < {1'b0, h_eff};
    line_sum = {1'b0, rot_r} + {1'b0, dy};
    line     = (line_sum >= 3'd3) ? 2'(line_sum - 3'd3) : line_sum[1:0];
    mem_ra   = cmd.rd_cur ? cur_addr : {line, tx[COL_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      slot_r <= '0;
    end else if (cmd.slot_next) begin
      slot_r <= slot_r + 1'b1;
    end
  end

  // Weighted error magnitude, then the shared divider.
  logic [PROD_W-1:0] prod_r, quotient;
  logic [ERR_W-1:0]  abs_err;
  logic              neg_r, div_busy, div_done;

  assign abs_err = err_r[ERR_W-1] ? ERR_W'(-err_r) : err_r;

  always_ff @(posedge clk) begin
    if (cmd.nb_issue) begin
      tgt_addr_r <= {line, tx[COL_W-1:0]};
      prod_r     <= abs_err[MAG_W-1:0] * wt;
      neg_r      <= err_r[ERR_W-1];
    end
  end

  mede_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (div_eff),
    .quotient (quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  logic [PROD_W:0]   contrib;
  logic [PROD_W+1:0] sum;

  always_comb begin
    contrib = neg_r ? (PROD_W+1)'(-{1'b0, quotient}) : {1'b0, quotient};
    sum     = {{(PROD_W-14){rdata_r[15]}}, rdata_r} + {contrib[PROD_W], contrib};
    if ($signed(sum) > $signed((PROD_W+2)'(32767))) begin
      sat_sum = 16'h7fff;
    end else if ($signed(sum) < $signed(-(PROD_W+2)'(32768))) begin
      sat_sum = 16'h8000;
    end else begin
      sat_sum = sum[15:0];
    end
  end

  // Output register.
  logic       out_valid_r, out_last_r;
  logic [7:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= ov_r;
      out_last_r <= last_col_r && last_row_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts.clr_last  = clr_addr_r == clr_end_r;
    sts.opaque    = opq_r;
    sts.slot_ok   = (wt != 8'd0) && tx_ok && row_ok;
    sts.slot_last = slot_r == SLOT_W'(NUM_SLOTS - 1);
    sts.div_done  = div_done;
    sts.div_busy  = div_busy;
    sts.out_free  = !out_valid_r || out_tready;
    sts.row_end   = last_col_r;
  end

endmodule
